FILE: hw/rtl/dro_pkg.sv
// Shared types and constants for the dead-reckoning odometry block.
package dro_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int ATAN_STEPS      = 24;
  localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_STEPS) ? TRIG_ITERATIONS : ATAN_STEPS;
  localparam int ITER_W          = $clog2(ATAN_STEPS);

  localparam int XY_W  = 20;   // CORDIC x/y working width, headroom over Q1.15
  localparam int Z_W   = 34;   // residual angle, 32-bit turns plus growth

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(19898);
  localparam logic [15:0]            INV_PERIOD_RESET = 16'd2560;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [31:0] ATAN_TURNS [ATAN_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_FIN,
    ST_MX,
    ST_AX,
    ST_MY,
    ST_AY,
    ST_MS,
    ST_MT,
    ST_RT,
    ST_OUT
  } dro_state_t;

endpackage

FILE: hw/rtl/dead_reckoning_odometry.sv
// Dead-reckoning pose tracker: iterative CORDIC plus one shared multiplier.
// Update transaction: the CORDIC step loop runs CORDIC_STEPS iterations, then four passes go
//   through the shared 16x17 multiplier. Clear transaction: skips both and goes to output.
// The result is loaded into the output register from ST_OUT once that register is free;
//   a new input is taken while that result still waits.
// Reset (synchronous, rst_n low): pose cleared, inverse period 2560, output empty.
module dead_reckoning_odometry
  import dro_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,   // inverse_period, Q8.8
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,      // [15:0] distance, [31:16] turn
  input  logic         in_tuser,      // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata      // [31:0] pos_x, [63:32] pos_y, [79:64] bearing,
                                      // [103:80] speed, [127:104] turn_rate
);

  dro_state_t state_r, state_nxt;

  logic [15:0]              inv_period_r;
  logic signed [31:0]       x_acc_r, y_acc_r;
  logic signed [15:0]       heading_r;
  logic signed [15:0]       dist_r, turn_r;
  logic signed [XY_W-1:0]   cx_r, cy_r;
  logic signed [Z_W-1:0]    z_r;
  logic                     flip_r;
  logic [ITER_W-1:0]        iter_r;
  logic signed [32:0]       prod_r;
  logic [23:0]              speed_r, rate_r;
  logic                     out_tvalid_r;
  logic [127:0]             out_tdata_r;

  logic                     in_acc;
  logic                     out_load;
  logic signed [15:0]       mul_a;
  logic signed [16:0]       mul_b;
  logic signed [32:0]       mul_p;

  // input fields
  logic signed [15:0] in_dist, in_turn;
  assign in_dist = in_tdata[15:0];
  assign in_turn = in_tdata[31:16];

  // midpoint angle as a 32-bit turn fraction, folded into [-pi/2, pi/2)
  logic [16:0]        mid17;
  logic [31:0]        angle;
  logic               flip;
  assign mid17 = 17'({heading_r, 1'b0}) + 17'(in_turn);
  assign angle = {mid17, 15'd0};
  assign flip  = angle[31] ^ angle[30];

  // one CORDIC rotation step
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  atan_z;
  logic                   z_pos;
  assign dx     = cy_r >>> iter_r;
  assign dy     = cx_r >>> iter_r;
  assign atan_z = Z_W'(ATAN_TURNS[iter_r]);
  assign z_pos  = !z_r[Z_W-1];

  // sign fix and clamp to Q1.15
  function automatic logic signed [XY_W-1:0] fix_q15(input logic signed [XY_W-1:0] v,
                                                     input logic neg);
    logic signed [XY_W-1:0] t;
    t = neg ? -v : v;
    if (t > XY_W'(32767))
      return XY_W'(32767);
    else if (t < -XY_W'(32768))
      return -XY_W'(32768);
    return t;
  endfunction

  // round half up, then saturating accumulate
  function automatic logic signed [31:0] acc_step(input logic signed [31:0] acc,
                                                  input logic signed [32:0] p);
    logic signed [32:0] r;
    logic signed [33:0] s;
    r = p + 33'sd16384;
    s = 34'(acc) + 34'($signed(r[32:15]));
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111)
      return s[31:0];
    return s[33] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  assign mul_p = 33'(mul_a) * 33'(mul_b);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc)
          state_nxt = (in_tuser == CMD_CLEAR) ? ST_OUT : ST_ROT;
      end
      ST_ROT: begin
        if (iter_r == ITER_W'(CORDIC_STEPS - 1))
          state_nxt = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_MX;
      ST_MX:   state_nxt = ST_AX;
      ST_AX:   state_nxt = ST_MY;
      ST_MY:   state_nxt = ST_AY;
      ST_AY:   state_nxt = ST_MS;
      ST_MS:   state_nxt = ST_MT;
      ST_MT:   state_nxt = ST_RT;
      ST_RT:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load)
          state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);
    mul_a     = dist_r;
    mul_b     = 17'({1'b0, inv_period_r});
    case (state_r)
      ST_MX:   mul_b = {cx_r[15], cx_r[15:0]};
      ST_MY:   mul_b = {cy_r[15], cy_r[15:0]};
      ST_MS:   mul_a = dist_r;
      ST_MT:   mul_a = turn_r;
      default: mul_a = dist_r;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      inv_period_r <= INV_PERIOD_RESET;
      x_acc_r      <= '0;
      y_acc_r      <= '0;
      heading_r    <= '0;
      out_tvalid_r <= 1'b0;
      iter_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en)
        inv_period_r <= cfg_wr_data;
      if (out_load)
        out_tvalid_r <= 1'b1;
      else if (out_tready)
        out_tvalid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          iter_r <= '0;
          if (in_acc) begin
            if (in_tuser == CMD_CLEAR) begin
              x_acc_r   <= '0;
              y_acc_r   <= '0;
              heading_r <= '0;
            end else begin
              heading_r <= heading_r + in_turn;
            end
          end
        end
        ST_ROT:  iter_r <= iter_r + ITER_W'(1);
        ST_AX:   x_acc_r <= acc_step(x_acc_r, prod_r);
        ST_AY:   y_acc_r <= acc_step(y_acc_r, prod_r);
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dist_r  <= in_dist;
          turn_r  <= in_turn;
          flip_r  <= flip;
          z_r     <= Z_W'($signed({angle[31] ^ flip, angle[30:0]}));
          cx_r    <= CORDIC_GAIN;
          cy_r    <= '0;
          speed_r <= '0;
          rate_r  <= '0;
        end
      end
      ST_ROT: begin
        if (z_pos) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          z_r  <= z_r - atan_z;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          z_r  <= z_r + atan_z;
        end
      end
      ST_FIN: begin
        cx_r <= fix_q15(cx_r, flip_r);
        cy_r <= fix_q15(cy_r, flip_r);
      end
      ST_MX, ST_MY, ST_MS: prod_r <= mul_p;
      ST_MT: begin
        speed_r <= prod_r[31:8];
        prod_r  <= mul_p;
      end
      ST_RT:   rate_r <= prod_r[31:8];
      default: ;
    endcase
    if (out_load)
      out_tdata_r <= {rate_r, speed_r, heading_r, y_acc_r, x_acc_r};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: hw/rtl/dro_checker.sv
// Port-level checks for the odometry block, bound to the top level.
module dro_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transaction");

  // one item at a time: busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous item in progress");

  // reset leaves the block idle with no result pending
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

  // stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

endmodule

bind dead_reckoning_odometry dro_checker u_dro_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/testbench.sv
// Self-checking testbench for the dead-reckoning odometry block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dro_pkg::*;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] bearing;
    logic signed [23:0] speed;
    logic signed [23:0] turn_rate;
  } pose_t;

  class pose_tracker;
    localparam int STEPS = 16;
    localparam longint GAIN_Q15 = 19898;
    localparam bit [31:0] ARCTAN [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [15:0] heading;
    bit [15:0]          inv_period;
    pose_t              pending_poses[$];
    int                 errors;
    int                 updates;
    int                 clears;

    function new();
      x_pos = 0;
      y_pos = 0;
      heading = 0;
      inv_period = INV_PERIOD_RESET;
      errors = 0;
      updates = 0;
      clears = 0;
    endfunction

    function void set_period(bit [15:0] v);
      inv_period = v;
    endfunction

    // rotation-mode CORDIC, angle in 32-bit turns, results in Q1.15
    function void sin_cos(input bit [31:0] angle, output longint c, output longint s);
      bit [31:0] probe;
      bit flip;
      longint x, y, z, dx, dy;
      probe = angle + 32'h4000_0000;
      flip = probe[31];
      if (flip)
        angle = angle + 32'h8000_0000;
      z = longint'(signed'(angle));
      x = GAIN_Q15;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(ARCTAN[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(ARCTAN[i]);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
      s = (y > 32767) ? 32767 : (y < -32768) ? -32768 : y;
    endfunction

    function logic signed [31:0] sat_add(logic signed [31:0] acc, longint delta);
      longint t;
      t = longint'(acc) + delta;
      if (t > 64'sd2147483647)
        return 32'sh7FFF_FFFF;
      if (t < -64'sd2147483648)
        return 32'sh8000_0000;
      return t[31:0];
    endfunction

    // advance the pose with one accepted transaction and queue the resulting pose
    function void take_step(logic cmd, logic signed [15:0] travel, logic signed [15:0] turn);
      pose_t      r;
      bit [16:0]  mid;
      longint     c, s, sp, tr;
      sp = 0;
      tr = 0;
      if (cmd == CMD_CLEAR) begin
        x_pos = 0;
        y_pos = 0;
        heading = 0;
        clears++;
      end else begin
        // midpoint heading at double resolution: 2*heading + turn
        mid = 17'(2 * longint'(heading) + longint'(turn));
        sin_cos({mid, 15'b0}, c, s);
        x_pos = sat_add(x_pos, (longint'(travel) * c + 16384) >>> 15);
        y_pos = sat_add(y_pos, (longint'(travel) * s + 16384) >>> 15);
        heading = 16'(heading + turn);
        sp = (longint'(travel) * longint'(inv_period)) >>> 8;
        tr = (longint'(turn) * longint'(inv_period)) >>> 8;
        updates++;
      end
      r.pos_x = x_pos;
      r.pos_y = y_pos;
      r.bearing = heading;
      r.speed = sp[23:0];
      r.turn_rate = tr[23:0];
      pending_poses.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30)
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_pose(logic [127:0] data);
      pose_t e;
      pose_t g;
      if (pending_poses.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      e = pending_poses.pop_front();
      g.pos_x = data[31:0];
      g.pos_y = data[63:32];
      g.bearing = data[79:64];
      g.speed = data[103:80];
      g.turn_rate = data[127:104];
      if (g.pos_x !== e.pos_x)
        report($sformatf("pos_x got %0d want %0d", g.pos_x, e.pos_x));
      if (g.pos_y !== e.pos_y)
        report($sformatf("pos_y got %0d want %0d", g.pos_y, e.pos_y));
      if (g.bearing !== e.bearing)
        report($sformatf("bearing got %0d want %0d", g.bearing, e.bearing));
      if (g.speed !== e.speed)
        report($sformatf("speed got %0d want %0d", g.speed, e.speed));
      if (g.turn_rate !== e.turn_rate)
        report($sformatf("turn_rate got %0d want %0d", g.turn_rate, e.turn_rate));
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [15:0]  cfg_wr_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;   // [15:0] distance, [31:16] turn
  logic         in_tuser;   // cmd
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // pos_x, pos_y, bearing, speed, turn_rate from bit 0 up

  pose_tracker  tracker;
  bit           steady;     // when set, neither side idles
  int           periods_used;

  dead_reckoning_odometry u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (steady)
      out_tready <= 1'b1;
    else
      out_tready <= ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_pose(out_tdata);
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task send_item(logic cmd, logic signed [15:0] travel, logic signed [15:0] turn);
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {turn, travel};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    tracker.take_step(cmd, travel, turn);
    @(negedge clk);
  endtask

  task random_items(int n);
    logic signed [15:0] travel;
    logic signed [15:0] turn;
    int                 pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      travel = 16'($urandom);
      turn = 16'($urandom);
      if (pick < 10) begin
        send_item(CMD_CLEAR, travel, turn);
      end else begin
        if (pick < 40)
          travel = 16'($signed($urandom_range(0, 400)) - 200);
        if (pick >= 30 && pick < 55)
          turn = 16'($signed($urandom_range(0, 2048)) - 1024);
        send_item(CMD_UPDATE, travel, turn);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // wait until every queued pose has come out, then let the block settle
  task drain();
    int n;
    n = 0;
    while (tracker.pending_poses.size() != 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
    if (tracker.pending_poses.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending_poses.size()));
    repeat (40) @(negedge clk);
  endtask

  task write_period(bit [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_period(v);
    periods_used++;
  endtask

  initial begin
    tracker = new();
    steady = 1'b0;
    periods_used = 1;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_UPDATE;
    out_tready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset period
    send_item(CMD_UPDATE, 16'sd0, 16'sd0);
    send_item(CMD_UPDATE, 16'sd32767, 16'sd0);
    send_item(CMD_UPDATE, -16'sd32768, 16'sd0);
    send_item(CMD_UPDATE, 16'sd1000, 16'sd32767);
    send_item(CMD_UPDATE, 16'sd1000, -16'sd32768);
    send_item(CMD_CLEAR, -16'sd1, -16'sd1);        // fields must be ignored
    send_item(CMD_UPDATE, 16'sd500, 16'sd16384);   // midpoint at pi/4
    send_item(CMD_UPDATE, 16'sd500, 16'sd16384);   // midpoint past pi/2, flipped half
    send_item(CMD_UPDATE, 16'sd32767, 16'sd32767);
    send_item(CMD_UPDATE, -16'sd32768, -16'sd32768);
    send_item(CMD_UPDATE, 16'sd0, 16'sd1);
    send_item(CMD_UPDATE, 16'sd0, -16'sd1);
    send_item(CMD_CLEAR, 16'sd0, 16'sd0);
    send_item(CMD_UPDATE, 16'sd7000, -16'sd32768); // midpoint exactly -pi/2
    send_item(CMD_CLEAR, 16'sd12345, 16'sd4321);
    send_item(CMD_UPDATE, 16'sd0, 16'sd16384);
    send_item(CMD_UPDATE, 16'sd7000, 16'sd0);      // midpoint exactly +pi/2
    send_item(CMD_UPDATE, -16'sd7000, 16'sd16384); // heading reaches pi, wraps
    send_item(CMD_UPDATE, 16'sd32767, -16'sd32768);
    send_item(CMD_UPDATE, -16'sd1, 16'sd32767);
    random_items(110);
    drain();

    steady = 1'b1;
    write_period(16'hFFFF);
    random_items(120);
    drain();
    steady = 1'b0;

    write_period(16'd1);
    random_items(110);
    drain();

    write_period(16'd0);
    send_item(CMD_UPDATE, -16'sd32768, 16'sd32767);
    random_items(100);
    drain();

    write_period(16'($urandom));
    random_items(120);
    drain();

    write_period(16'd256);
    random_items(110);
    drain();

    $display("Covered %0d pose updates and %0d clears over %0d inverse-period settings,",
             tracker.updates, tracker.clears, periods_used);
    $display("including 0, 1 and 65535, with random stalls on both streams.");
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d results outstanding", tracker.pending_poses.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
